// File: design/wdr_pkg.sv
// shared types and constants for the windowed discounted return unit
package wdr_pkg;

  localparam int unsigned GAMMA_W   = 17;
  localparam int unsigned SAMPLE_W  = 32;
  localparam int unsigned SUM_W     = 37;
  localparam int unsigned FRAC_W    = 16;
  localparam int unsigned PROD_W    = SAMPLE_W + GAMMA_W + 1;

  localparam logic [GAMMA_W-1:0] GAMMA_ONE = 17'h10000;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_TERM,
    ST_WGT,
    ST_WNEW,
    ST_OUT
  } wdr_state_t;

endpackage

// File: design/windowed_discounted_return_unit.sv
// top level of the windowed discounted return unit
//
// Reward samples (signed Q16.16) arrive on the in_ channel, the final sample of a stream
// flagged by in_last_sample. Results (signed Q21.16) leave on the out_ channel; each is
// the sum of the next WINDOW samples from one position, weighted by gamma^j, where gamma
// is written on the cfg_ channel (unsigned Q1.16, values above 1.0 act as 1.0).
// Up to WINDOW samples are held in a circular buffer. An item that fills the buffer gives
// one result for the oldest sample; a last item flushes every held sample, oldest first,
// each window cut at the end of the stream, and only the final one has out_last_result.
// An item that gives no result leaves in_ready high. Each result walks its window through one
// shared 32x18 multiplier, each term in turn as term product, weight update and weight
// load, and a flush walks one window per held sample. in_ready is low meanwhile.
// A finished result sits in an output register; the next result is computed while it
// waits, and the walk stalls only when a second result is ready before the receiver
// takes the first. The cfg_ channel is always ready.
// Reset empties the buffer, drops any pending result and sets gamma to 1.0.
module windowed_discounted_return_unit
  import wdr_pkg::*;
#(
  parameter int unsigned WINDOW = 24
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic signed [SAMPLE_W-1:0] in_reward_sample,
  input  logic                       in_last_sample,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic signed [SUM_W-1:0]    out_discounted_sum,
  output logic                       out_last_result,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [GAMMA_W-1:0]         cfg_discount_factor
);

  localparam int unsigned IW = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int unsigned CW = $clog2(WINDOW + 1);
  localparam int unsigned SW = IW + 1;
  localparam int unsigned AW = 54 + $clog2(WINDOW);

  function automatic logic [IW-1:0] ptr_inc(input logic [IW-1:0] p);
    logic [IW-1:0] r;
    if (p == IW'(WINDOW - 1)) begin
      r = '0;
    end else begin
      r = p + 1'b1;
    end
    return r;
  endfunction

  wdr_state_t state_r, state_nxt;

  logic [GAMMA_W-1:0]         gamma_r;
  logic [CW-1:0]              count_r, count_nxt;
  logic [IW-1:0]              head_r, head_nxt;
  logic [IW-1:0]              start_r, start_nxt;
  logic [IW-1:0]              rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]              len_r, len_nxt;
  logic [CW-1:0]              term_left_r, term_left_nxt;
  logic [CW-1:0]              results_left_r, results_left_nxt;
  logic                       flush_r, flush_nxt;
  logic [GAMMA_W-1:0]         w_r, w_nxt;
  logic signed [AW-1:0]       acc_r, acc_nxt;
  logic signed [PROD_W-1:0]   prod_r, prod_nxt;
  logic signed [SAMPLE_W-1:0] mem_q_r;
  logic                       out_valid_r, out_valid_nxt;
  logic signed [SUM_W-1:0]    out_sum_r;
  logic                       out_last_r;

  logic signed [SAMPLE_W-1:0] mem [WINDOW];

  logic                       in_xfer;
  logic                       out_free;
  logic                       gives_result;
  logic                       rd_en;
  logic [IW-1:0]              rd_addr;
  logic [SW-1:0]              wr_sum;
  logic [IW-1:0]              wr_addr;
  logic [GAMMA_W-1:0]         gamma_eff;
  logic signed [SAMPLE_W-1:0] mul_a;
  logic [GAMMA_W-1:0]         mul_b;
  logic signed [PROD_W-1:0]   mul_p;

  assign in_ready  = (state_r == ST_IDLE);
  assign cfg_ready = 1'b1;
  assign in_xfer   = in_valid && in_ready;
  assign out_free  = !out_valid_r || out_ready;
  assign gives_result = in_last_sample || (count_r == CW'(WINDOW - 1));

  assign out_valid          = out_valid_r;
  assign out_discounted_sum = out_sum_r;
  assign out_last_result    = out_last_r;

  assign gamma_eff = (gamma_r > GAMMA_ONE) ? GAMMA_ONE : gamma_r;

  assign wr_sum  = SW'(head_r) + SW'(count_r);
  assign wr_addr = (wr_sum >= SW'(WINDOW)) ? IW'(wr_sum - SW'(WINDOW)) : IW'(wr_sum);

  assign rd_en   = (state_r == ST_LOAD) || (state_r == ST_TERM);
  assign rd_addr = (state_r == ST_LOAD) ? start_r : rd_ptr_r;

  // shared multiplier: sample times weight, or weight times gamma
  always_comb begin
    if (state_r == ST_WGT) begin
      mul_a = $signed({{(SAMPLE_W - GAMMA_W){1'b0}}, w_r});
      mul_b = gamma_eff;
    end else begin
      mul_a = mem_q_r;
      mul_b = w_r;
    end
  end

  assign mul_p = PROD_W'(mul_a) * PROD_W'($signed({1'b0, mul_b}));

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      mem[wr_addr] <= in_reward_sample;
    end
    if (rd_en) begin
      mem_q_r <= mem[rd_addr];
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_xfer && gives_result) begin
          state_nxt = ST_LOAD;
        end
      end
      ST_LOAD: state_nxt = ST_TERM;
      ST_TERM: state_nxt = ST_WGT;
      ST_WGT:  state_nxt = ST_WNEW;
      ST_WNEW: begin
        if (term_left_r == '0) begin
          state_nxt = ST_OUT;
        end else begin
          state_nxt = ST_TERM;
        end
      end
      ST_OUT: begin
        if (out_free) begin
          state_nxt = (results_left_r == CW'(1)) ? ST_IDLE : ST_LOAD;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    count_nxt        = count_r;
    head_nxt         = head_r;
    start_nxt        = start_r;
    rd_ptr_nxt       = rd_ptr_r;
    len_nxt          = len_r;
    term_left_nxt    = term_left_r;
    results_left_nxt = results_left_r;
    flush_nxt        = flush_r;
    w_nxt            = w_r;
    acc_nxt          = acc_r;
    prod_nxt         = prod_r;
    out_valid_nxt    = out_valid_r && !out_ready;
    unique case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          start_nxt = head_r;
          flush_nxt = in_last_sample;
          if (in_last_sample) begin
            len_nxt          = count_r + 1'b1;
            results_left_nxt = count_r + 1'b1;
            count_nxt        = '0;
          end else if (count_r == CW'(WINDOW - 1)) begin
            len_nxt          = CW'(WINDOW);
            results_left_nxt = CW'(1);
            head_nxt         = ptr_inc(head_r);
          end else begin
            count_nxt = count_r + 1'b1;
          end
        end
      end
      ST_LOAD: begin
        rd_ptr_nxt    = ptr_inc(start_r);
        term_left_nxt = len_r;
        w_nxt         = GAMMA_ONE;
        acc_nxt       = '0;
      end
      ST_TERM: begin
        prod_nxt   = mul_p;
        rd_ptr_nxt = ptr_inc(rd_ptr_r);
      end
      ST_WGT: begin
        acc_nxt       = acc_r + AW'(prod_r);
        prod_nxt      = mul_p;
        term_left_nxt = term_left_r - 1'b1;
      end
      ST_WNEW: begin
        w_nxt = prod_r[FRAC_W +: GAMMA_W];
      end
      ST_OUT: begin
        if (out_free) begin
          out_valid_nxt    = 1'b1;
          start_nxt        = ptr_inc(start_r);
          len_nxt          = len_r - 1'b1;
          results_left_nxt = results_left_r - 1'b1;
        end
      end
      default: begin
        out_valid_nxt = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ST_IDLE;
      gamma_r        <= GAMMA_ONE;
      count_r        <= '0;
      head_r         <= '0;
      results_left_r <= '0;
      term_left_r    <= '0;
      flush_r        <= 1'b0;
      out_valid_r    <= 1'b0;
    end else begin
      state_r        <= state_nxt;
      count_r        <= count_nxt;
      head_r         <= head_nxt;
      results_left_r <= results_left_nxt;
      term_left_r    <= term_left_nxt;
      flush_r        <= flush_nxt;
      out_valid_r    <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        gamma_r <= cfg_discount_factor;
      end
    end
  end

  always_ff @(posedge clk) begin
    start_r  <= start_nxt;
    rd_ptr_r <= rd_ptr_nxt;
    len_r    <= len_nxt;
    w_r      <= w_nxt;
    acc_r    <= acc_nxt;
    prod_r   <= prod_nxt;
    if (state_r == ST_OUT && out_free) begin
      out_sum_r  <= acc_r[FRAC_W +: SUM_W];
      out_last_r <= flush_r && (results_left_r == CW'(1));
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(WINDOW - 1))
    else $error("held sample count above window minus one");

  a_last_empties: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer && in_last_sample |=> count_r == '0)
    else $error("last transfer did not empty the buffer");

  a_term_pending: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_TERM |-> term_left_r != '0)
    else $error("term step with no term left");

  a_out_from_seq: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == ST_OUT)
    else $error("result raised outside the output step");

  a_flush_count: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_OUT && !flush_r |-> results_left_r == CW'(1))
    else $error("single result pass with more than one result left");
`endif

endmodule
